/* hdl/tcce_pkg.sv */
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file references this package by scoped name.
package tcce_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int IDX_W   = 11;

   // Result queue, power of two
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Operation codes
   localparam logic [1:0] OP_FG_CHAR   = 2'd0;
   localparam logic [1:0] OP_ATTR_CHAR = 2'd1;
   localparam logic [1:0] OP_BLINK     = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   // Character codes and fixed attribute
   localparam logic [7:0] CH_RETURN     = 8'd13;
   localparam logic [7:0] CH_NEWLINE    = 8'd10;
   localparam logic [7:0] CH_BACKSPACE  = 8'd8;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] WHITE_ATTR    = 8'h0F;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic [7:0] color;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] cell_index;
      logic [7:0]       cell_char;
      logic [7:0]       cell_attribute;
      logic             attribute_valid;
      logic             last_write;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

/* hdl/tcce_shadow_ram.sv */
// Screen character shadow: one write port, one read port, registered read data.
// Depends on tcce_pkg.
module tcce_shadow_ram (
   input  logic                 clock,
   input  tcce_pkg::mem_req_type mem_req,
   output logic [7:0]           rdata
);

   logic [7:0] cells_ff [tcce_pkg::CELLS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         cells_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= cells_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/tcce_out_fifo.sv */
// Small result queue between the cursor sequencer and the rsp channel.
// Depends on tcce_pkg.
module tcce_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcce_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcce_pkg::rsp_type rsp_payload
);

   tcce_pkg::rsp_type                    entries_ff [tcce_pkg::FIFO_DEPTH];
   logic [tcce_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tcce_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tcce_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic                                 pop;

   assign full        = (count_ff == tcce_pkg::FIFO_CNT_W'(tcce_pkg::FIFO_DEPTH));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entries_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/tcce_cursor_ctrl.sv */
// Cursor sequencer: holds cursor, blink and color state, takes one item at a time,
// stalls a write while the result queue is full, and drives the shadow memory. Depends on tcce_pkg.
module tcce_cursor_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcce_pkg::req_type     req_payload,
   input  logic                  fifo_full,
   output logic                  push,
   output tcce_pkg::rsp_type     push_data,
   output tcce_pkg::mem_req_type mem_req,
   input  logic [7:0]            mem_rdata
);

   logic                            busy_ff, busy_in;
   logic                            phase_ff, phase_in;
   tcce_pkg::req_type               item_ff;
   logic [tcce_pkg::COL_W-1:0]      col_ff, col_in;
   logic [tcce_pkg::ROW_W-1:0]      row_ff, row_in;
   logic                            uline_ff, uline_in;
   logic [7:0]                      saved_ff, saved_in;
   logic [3:0]                      bg_ff;
   logic                            clearing_ff;
   logic [tcce_pkg::IDX_W-1:0]      clr_addr_ff;

   logic [tcce_pkg::IDX_W-1:0]      here;
   logic [7:0]                      attr, bs_attr;
   logic [tcce_pkg::ROW_W-1:0]      row_next;
   logic                            emit, e_av, e_last, last_step, rd_en;
   logic [7:0]                      e_char, e_attr;
   logic                            go, finish, accept;

   assign here = tcce_pkg::IDX_W'(row_ff) * tcce_pkg::IDX_W'(tcce_pkg::COLUMNS)
               + tcce_pkg::IDX_W'(col_ff);
   assign row_next = (row_ff == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)) ? '0 : row_ff + 1'b1;

   always_comb begin
      attr      = (item_ff.op == tcce_pkg::OP_FG_CHAR) ?
                  {bg_ff, item_ff.color[3:0]} : item_ff.color;
      bs_attr   = (item_ff.op == tcce_pkg::OP_FG_CHAR) ? attr : tcce_pkg::WHITE_ATTR;
      emit      = 1'b0;
      e_char    = tcce_pkg::CH_SPACE;
      e_attr    = '0;
      e_av      = 1'b0;
      e_last    = 1'b1;
      last_step = 1'b1;
      rd_en     = 1'b0;
      col_in    = col_ff;
      row_in    = row_ff;
      uline_in  = uline_ff;
      saved_in  = saved_ff;
      unique case (item_ff.op) inside
         tcce_pkg::OP_BLINK: begin
            if (uline_ff) begin
               emit     = 1'b1;
               e_char   = saved_ff;
               e_attr   = tcce_pkg::WHITE_ATTR;
               e_av     = 1'b1;
               uline_in = 1'b0;
            end else if (!phase_ff) begin
               // fetch the character under the cursor first
               rd_en     = 1'b1;
               last_step = 1'b0;
            end else begin
               emit     = 1'b1;
               e_char   = tcce_pkg::CH_UNDERSCORE;
               saved_in = mem_rdata;
               uline_in = 1'b1;
            end
         end
         tcce_pkg::OP_FG_CHAR, tcce_pkg::OP_ATTR_CHAR: begin
            unique case (item_ff.char_code)
               tcce_pkg::CH_RETURN: begin
                  emit   = 1'b1;
                  e_attr = attr;
                  e_av   = 1'b1;
                  col_in = '0;
               end
               tcce_pkg::CH_NEWLINE: begin
                  col_in = '0;
                  row_in = row_next;
               end
               tcce_pkg::CH_BACKSPACE: begin
                  emit   = 1'b1;
                  e_attr = bs_attr;
                  e_av   = 1'b1;
                  if (!phase_ff) begin
                     e_last    = 1'b0;
                     last_step = 1'b0;
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end else if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                        col_in = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
                     end
                  end else begin
                     uline_in = 1'b0;
                  end
               end
               default: begin
                  emit   = 1'b1;
                  e_char = item_ff.char_code;
                  e_attr = attr;
                  e_av   = 1'b1;
                  if (col_ff == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1)) begin
                     col_in = '0;
                     row_in = row_next;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign go        = busy_ff && (!emit || !fifo_full);
   assign finish    = go && last_step;
   assign req_ready = !clearing_ff && (!busy_ff || finish);
   assign accept    = req_valid && req_ready;
   assign busy_in   = accept || (busy_ff && !finish);
   assign phase_in  = go ? !last_step : phase_ff;

   assign push                     = go && emit;
   assign push_data.cell_index     = here;
   assign push_data.cell_char      = e_char;
   assign push_data.cell_attribute = e_av ? e_attr : '0;
   assign push_data.attribute_valid = e_av;
   assign push_data.last_write     = e_last;

   // shadow port: clearing sweep after reset, then cell writes and blink reads
   assign mem_req.we    = clearing_ff || push;
   assign mem_req.waddr = clearing_ff ? clr_addr_ff : here;
   assign mem_req.wdata = clearing_ff ? tcce_pkg::CH_SPACE : e_char;
   assign mem_req.re    = go && rd_en;
   assign mem_req.raddr = here;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         phase_ff    <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         uline_ff    <= 1'b0;
         saved_ff    <= tcce_pkg::CH_SPACE;
         bg_ff       <= '0;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         if (go) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            uline_ff <= uline_in;
            saved_ff <= saved_in;
         end
         if (csr_wr_en) begin
            bg_ff <= csr_wr_data;
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == tcce_pkg::IDX_W'(tcce_pkg::CELLS - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

endmodule

/* hdl/text_console_cursor_engine_core.sv */
// Top level of the text console cursor engine: sequencer, shadow RAM, result queue.
// Depends on tcce_pkg, tcce_cursor_ctrl, tcce_shadow_ram, tcce_out_fifo.
//
//   port group | direction | handshake              | payload
//   req_*      | in        | req_valid / req_ready  | req_payload   (tcce_pkg::req_type)
//   rsp_*      | out       | rsp_valid / rsp_ready  | rsp_payload   (tcce_pkg::rsp_type)
//   csr_*      | in        | csr_wr_en, no wait     | csr_wr_data   (background nibble)
//
// Printable chars, return, line feed, unused op and blink restore need no second phase;
// backspace (two cell writes) and blink show (shadow read, then write) need a second.
// Both are set by the single shadow write port and its registered read data.
// After reset a clearing sweep fills all CELLS (2000) shadow cells with spaces: req_ready
// stays low until the sweep ends. csr writes are taken during the sweep.
// Results go through a 2-entry queue; the sequencer holds only when it is full.
module text_console_cursor_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcce_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcce_pkg::rsp_type rsp_payload
);

   tcce_pkg::mem_req_type mem_req;
   logic [7:0]            mem_rdata;
   logic                  fifo_full;
   logic                  push;
   tcce_pkg::rsp_type     push_data;

   tcce_cursor_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .fifo_full   (fifo_full),
      .push        (push),
      .push_data   (push_data),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata)
   );

   tcce_shadow_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   tcce_out_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .full        (fifo_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/tcce_checker.sv */
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_core.
module tcce_port_assert (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcce_pkg::rsp_type rsp_payload
);

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // queue is empty coming out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // shadow clearing sweep blocks input right after reset
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during clearing sweep");

endmodule

bind text_console_cursor_engine_core tcce_port_assert u_tcce_port_assert (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/tcce_checker.sv */
// Checker for the text console cursor engine: watches the request, result and csr ports,
// predicts the cell writes each transfer causes and compares them in order.
// Depends on tcce_pkg.
module tcce_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tcce_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tcce_pkg::rsp_type rsp_payload,
   output int                mismatch_count,
   output int                pending_writes
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [3:0]        background;
   int                cur_col;
   int                cur_row;
   bit                underscore_on;
   logic [7:0]        saved_char;
   logic [7:0]        screen_chars [tcce_pkg::CELLS];
   tcce_pkg::rsp_type cell_write_q [$];

   function automatic int cursor_cell();
      return cur_row * tcce_pkg::COLUMNS + cur_col;
   endfunction

   // Updates the screen copy and builds one cell write
   function automatic tcce_pkg::rsp_type cell_write(input int idx, input logic [7:0] ch,
                                                    input logic [7:0] attr,
                                                    input bit with_attr);
      tcce_pkg::rsp_type w;
      screen_chars[idx] = ch;
      w.cell_index      = idx[tcce_pkg::IDX_W-1:0];
      w.cell_char       = ch;
      w.cell_attribute  = with_attr ? attr : 8'h00;
      w.attribute_valid = with_attr;
      w.last_write      = 1'b0;
      return w;
   endfunction

   task automatic predict_cell_writes(input tcce_pkg::req_type item);
      tcce_pkg::rsp_type w [2];
      int                n;
      logic [7:0]        attr;
      logic [7:0]        bs_attr;
      n = 0;
      if (item.op == tcce_pkg::OP_NONE)
         return;
      if (item.op == tcce_pkg::OP_BLINK) begin
         if (underscore_on) begin
            w[0] = cell_write(cursor_cell(), saved_char, tcce_pkg::WHITE_ATTR, 1'b1);
            underscore_on = 1'b0;
         end else begin
            saved_char = screen_chars[cursor_cell()];
            w[0] = cell_write(cursor_cell(), tcce_pkg::CH_UNDERSCORE, 8'h00, 1'b0);
            underscore_on = 1'b1;
         end
         n = 1;
      end else begin
         if (item.op == tcce_pkg::OP_FG_CHAR) begin
            attr    = {background, item.color[3:0]};
            bs_attr = attr;
         end else begin
            attr    = item.color;
            bs_attr = tcce_pkg::WHITE_ATTR;
         end
         case (item.char_code)
            tcce_pkg::CH_RETURN: begin
               w[n] = cell_write(cursor_cell(), tcce_pkg::CH_SPACE, attr, 1'b1);
               n++;
               cur_col = 0;
            end
            tcce_pkg::CH_NEWLINE: begin
               cur_col = 0;
               cur_row++;
            end
            tcce_pkg::CH_BACKSPACE: begin
               w[n] = cell_write(cursor_cell(), tcce_pkg::CH_SPACE, bs_attr, 1'b1);
               n++;
               if (cur_col > 0) begin
                  cur_col--;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = tcce_pkg::COLUMNS - 1;
               end
               w[n] = cell_write(cursor_cell(), tcce_pkg::CH_SPACE, bs_attr, 1'b1);
               n++;
               underscore_on = 1'b0;
            end
            default: begin
               w[n] = cell_write(cursor_cell(), item.char_code, attr, 1'b1);
               n++;
               cur_col++;
            end
         endcase
         if (cur_col >= tcce_pkg::COLUMNS) begin
            cur_col = 0;
            cur_row++;
         end
         // no scrolling: the bottom row wraps to the top
         if (cur_row >= tcce_pkg::ROWS)
            cur_row = 0;
      end
      if (n > 0)
         w[n-1].last_write = 1'b1;
      for (int i = 0; i < n; i++)
         cell_write_q.push_back(w[i]);
   endtask

   always @(posedge clock) begin : watch
      tcce_pkg::rsp_type want;
      if (reset) begin
         background    = 4'h0;
         cur_col       = 0;
         cur_row       = 0;
         underscore_on = 1'b0;
         saved_char    = tcce_pkg::CH_SPACE;
         foreach (screen_chars[i])
            screen_chars[i] = tcce_pkg::CH_SPACE;
         cell_write_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en)
            background = csr_wr_data;
         if (req_valid && req_ready)
            predict_cell_writes(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (cell_write_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected write idx=%0d char=%02h attr=%02h av=%0b last=%0b",
                           $realtime, rsp_payload.cell_index, rsp_payload.cell_char,
                           rsp_payload.cell_attribute, rsp_payload.attribute_valid,
                           rsp_payload.last_write);
               mismatch_count++;
            end else begin
               want = cell_write_q.pop_front();
               if (rsp_payload.cell_index !== want.cell_index ||
                   rsp_payload.cell_char !== want.cell_char ||
                   rsp_payload.cell_attribute !== want.cell_attribute ||
                   rsp_payload.attribute_valid !== want.attribute_valid ||
                   rsp_payload.last_write !== want.last_write) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: cell write mismatch: exp idx=%0d char=%02h attr=%02h",
                            $realtime, want.cell_index, want.cell_char,
                            want.cell_attribute);
                     $write(" av=%0b last=%0b, got idx=%0d char=%02h",
                            want.attribute_valid, want.last_write,
                            rsp_payload.cell_index, rsp_payload.cell_char);
                     $display(" attr=%02h av=%0b last=%0b", rsp_payload.cell_attribute,
                              rsp_payload.attribute_valid, rsp_payload.last_write);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      pending_writes = cell_write_q.size();
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for text_console_cursor_engine_core: clock, reset, character stream
// with bursts and gaps, result stalls, background color changes and the verdict.
// Depends on tcce_pkg, tcce_checker and the core RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_wr_en;
   logic [3:0] csr_wr_data;
   logic    req_valid;
   logic    req_ready;
   tcce_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   tcce_pkg::rsp_type rsp_payload;
   int      mismatch_count;
   int      pending_writes;

   int      burst_left;
   int      chars_sent;

   always #2 clock = ~clock;

   text_console_cursor_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tcce_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_writes (pending_writes)
   );

   // Result side stalls: rsp_ready follows one of four randomly chosen stall modes
   int       stall_cycle = 0;
   int       stall_mode  = 0;
   bit [7:0] stall_pattern = 8'hFF;
   always @(negedge clock) begin
      if (stall_cycle % 150 == 0) begin
         stall_mode    = $urandom_range(0, 3);
         stall_pattern = 8'($urandom) | 8'h01;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= stall_pattern[stall_cycle % 8];
         2:       rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= (stall_cycle % 16 == 0);
      endcase
      stall_cycle++;
   end

   // One transfer, then the burst/gap decision
   task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] color);
      req_payload.op        = op;
      req_payload.char_code = ch;
      req_payload.color     = color;
      req_valid             = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (op != tcce_pkg::OP_NONE)
         chars_sent++;
      @(negedge clock);
      req_valid = 1'b0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
      end
   endtask

   task automatic set_background(input logic [3:0] value);
      while (pending_writes != 0) @(negedge clock);
      // a line feed or ignored op may still be in flight with nothing expected
      repeat (8) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [7:0] printable();
      logic [7:0] c;
      do c = 8'($urandom);
      while (c == tcce_pkg::CH_BACKSPACE || c == tcce_pkg::CH_NEWLINE ||
             c == tcce_pkg::CH_RETURN);
      return c;
   endfunction

   function automatic logic [1:0] char_op();
      return $urandom_range(0, 1) ? tcce_pkg::OP_ATTR_CHAR : tcce_pkg::OP_FG_CHAR;
   endfunction

   task automatic random_text(input int count);
      int start;
      int len;
      int kind;
      start = chars_sent;
      while (chars_sent - start < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // a line of text, sometimes longer than the screen width
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(60, 120);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 19))
                  0, 1:    send(char_op(), tcce_pkg::CH_BACKSPACE, 8'($urandom));
                  2:       send(tcce_pkg::OP_BLINK, 8'($urandom), 8'($urandom));
                  default: send(char_op(), printable(), 8'($urandom));
               endcase
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  send(char_op(), tcce_pkg::CH_RETURN, 8'($urandom));
                  send(char_op(), tcce_pkg::CH_NEWLINE, 8'($urandom));
               end
               5, 6, 7: send(char_op(), tcce_pkg::CH_NEWLINE, 8'($urandom));
               default: send(char_op(), tcce_pkg::CH_RETURN, 8'($urandom));
            endcase
         end else if (kind < 70) begin
            send(tcce_pkg::OP_BLINK, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 3)) send(char_op(), printable(), 8'($urandom));
            send(tcce_pkg::OP_BLINK, 8'($urandom), 8'($urandom));
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 90))
               send(char_op(), tcce_pkg::CH_BACKSPACE, 8'($urandom));
         end else if (kind < 93) begin
            repeat ($urandom_range(1, 30))
               send(char_op(), tcce_pkg::CH_NEWLINE, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8))
               send(2'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 4'h0;
      req_valid   = 1'b0;
      req_payload = '0;
      burst_left  = 0;
      chars_sent  = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      set_background(4'hF);
      // directed: cursor starts at the top left corner
      send(tcce_pkg::OP_FG_CHAR,   tcce_pkg::CH_BACKSPACE, 8'h00); // both blanks on cell 0
      send(tcce_pkg::OP_ATTR_CHAR, 8'h41,                  8'hFF);
      send(tcce_pkg::OP_FG_CHAR,   8'h00,                  8'h0F);
      send(tcce_pkg::OP_FG_CHAR,   8'hFF,                  8'hF0);
      send(tcce_pkg::OP_ATTR_CHAR, tcce_pkg::CH_RETURN,    8'h00);
      send(tcce_pkg::OP_FG_CHAR,   tcce_pkg::CH_NEWLINE,   8'hAA);
      // steps back across the line start
      send(tcce_pkg::OP_ATTR_CHAR, tcce_pkg::CH_BACKSPACE, 8'h3C);
      send(tcce_pkg::OP_ATTR_CHAR, 8'h5A,                  8'h5A); // last column, wraps
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);
      send(tcce_pkg::OP_BLINK,     8'hFF,                  8'hFF);
      send(tcce_pkg::OP_FG_CHAR,   8'h78,                  8'h07);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);
      // cursor moves with underscore shown
      send(tcce_pkg::OP_FG_CHAR,   8'h79,                  8'h0E);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00); // restore on the new cell
      send(tcce_pkg::OP_NONE,      8'hFF,                  8'hFF);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);
      // clears the underscore flag
      send(tcce_pkg::OP_FG_CHAR,   tcce_pkg::CH_BACKSPACE, 8'h05);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);
      send(tcce_pkg::OP_ATTR_CHAR, tcce_pkg::CH_NEWLINE,   8'hFF);
      send(tcce_pkg::OP_FG_CHAR,   tcce_pkg::CH_RETURN,    8'h0C);
      send(tcce_pkg::OP_ATTR_CHAR, 8'h71,                  8'h1E);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);
      send(tcce_pkg::OP_BLINK,     8'h00,                  8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_background(4'h0);
            1:       set_background(4'hF);
            default: set_background(4'($urandom));
         endcase
         random_text(440);
      end

      while (pending_writes != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_writes == 0)
         $display("** text_console_cursor_engine_core: PASSED **");
      else
         $display("** text_console_cursor_engine_core: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** text_console_cursor_engine_core: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
hdl/tcce_pkg.sv
hdl/tcce_shadow_ram.sv
hdl/tcce_out_fifo.sv
hdl/tcce_cursor_ctrl.sv
hdl/text_console_cursor_engine_core.sv
hdl/tcce_checker.sv
tb/tcce_checker.sv
tb/tb_top.sv
